// ----- hdl/bsfe_pkg.sv -----
// bsfe_pkg: constants, register map and helper functions of the byte stuffed frame encoder
// no dependencies; imported by the interfaces, the top level and the checker
`timescale 1ns / 1ps
`default_nettype none

package bsfe_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned MaxOut   = 8;
  localparam int unsigned OutIdxW  = $clog2(MaxOut);
  localparam int unsigned OutCntW  = OutIdxW + 1;
  localparam int unsigned PaddrW   = 4;
  localparam int unsigned PdataW   = 32;

  localparam logic [ByteW-1:0] HeaderRst = 8'h7E;
  localparam logic [ByteW-1:0] EndRst    = 8'h7E;
  localparam logic [ByteW-1:0] EscapeRst = 8'h7D;
  localparam logic [ByteW-1:0] StuffMask = 8'h20;
  localparam logic [ByteW:0]   FletchMod = 9'd255;

  typedef enum logic [1:0] {
    REG_HEADER = 2'd0,
    REG_END    = 2'd1,
    REG_ESCAPE = 2'd2
  } reg_idx_e;

  typedef logic [ByteW-1:0] byte_t;

  typedef struct packed {
    logic  two;
    byte_t first;
    byte_t second;
  } stuffed_t;

  function automatic byte_t mod255_add(input byte_t a, input byte_t b);
    logic [ByteW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= FletchMod) begin
      s = s - FletchMod;
    end
    return s[ByteW-1:0];
  endfunction

  function automatic stuffed_t stuff(input byte_t b, input byte_t hdr, input byte_t eop,
                                     input byte_t esc);
    stuffed_t r;
    if (b == hdr || b == eop || b == esc) begin
      r.two    = 1'b1;
      r.first  = esc;
      r.second = b ^ StuffMask;
    end else begin
      r.two    = 1'b0;
      r.first  = b;
      r.second = b;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/bsfe_ifs.sv -----
// bsfe_in_if and bsfe_out_if: valid/ready channels of the frame encoder
// depends on bsfe_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bsfe_in_if
  import bsfe_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bsfe_out_if
  import bsfe_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  run_last;
  logic  frame_done;

  modport source (output valid, output out_byte, output run_last, output frame_done,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input frame_done,
                output ready);
endinterface

`default_nettype wire

// ----- hdl/byte_stuffed_frame_encoder_top.sv -----
// byte_stuffed_frame_encoder_top: hdlc-style byte stuffing with fletcher-16 trailer
// depends on bsfe_pkg, bsfe_in_if, bsfe_out_if
// flow: an accepted request waits in the input register and is loaded into the output buffer
//   once that is free; each request gives 1..8 wire bytes on the single output byte lane,
//   and the next request is loaded as the last byte leaves
// reset: async active low, clears sums, frame state, queues and restores delimiters
`timescale 1ns / 1ps
`default_nettype none

module byte_stuffed_frame_encoder_top
  import bsfe_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  bsfe_in_if.sink                in_i,
  bsfe_out_if.source             out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic      [PdataW-1:0] prdata,
  output logic                   pready
);

  byte_t hdr_q, end_q, esc_q;
  logic  in_frame_q;
  byte_t sum_lo_q, sum_hi_q;

  logic  in_vld_q;
  byte_t in_data_q;
  logic  in_last_q;

  byte_t               buf_q [MaxOut];
  byte_t               buf_d [MaxOut];
  logic                buf_vld_q;
  logic [OutIdxW-1:0]  idx_q;
  logic [OutIdxW-1:0]  last_idx_q;
  logic                done_q;

  logic                out_fire, buf_free, load, in_fire, cfg_we;
  byte_t               sum_lo_d, sum_hi_d;
  stuffed_t            st_data, st_lo, st_hi;
  logic [OutCntW-1:0]  n;
  logic [OutIdxW-1:0]  last_idx_d;
  reg_idx_e            reg_sel;

  // handshake
  assign out_fire = out_o.valid && out_o.ready;
  assign buf_free = !buf_vld_q || (out_fire && (idx_q == last_idx_q));
  assign load     = in_vld_q && buf_free;
  assign in_i.ready = !in_vld_q || load;
  assign in_fire  = in_i.valid && in_i.ready;

  // checksum and stuffing
  assign sum_lo_d = mod255_add(sum_lo_q, in_data_q);
  assign sum_hi_d = mod255_add(sum_hi_q, sum_lo_d);
  assign st_data  = stuff(in_data_q, hdr_q, end_q, esc_q);
  assign st_lo    = stuff(sum_lo_d, hdr_q, end_q, esc_q);
  assign st_hi    = stuff(sum_hi_d, hdr_q, end_q, esc_q);

  always_comb begin
    for (int i = 0; i < MaxOut; i++) begin
      buf_d[i] = '0;
    end
    n = '0;
    if (!in_frame_q) begin
      buf_d[n[OutIdxW-1:0]] = hdr_q;
      n = n + 1'b1;
    end
    buf_d[n[OutIdxW-1:0]] = st_data.first;
    n = n + 1'b1;
    if (st_data.two) begin
      buf_d[n[OutIdxW-1:0]] = st_data.second;
      n = n + 1'b1;
    end
    if (in_last_q) begin
      buf_d[n[OutIdxW-1:0]] = st_lo.first;
      n = n + 1'b1;
      if (st_lo.two) begin
        buf_d[n[OutIdxW-1:0]] = st_lo.second;
        n = n + 1'b1;
      end
      buf_d[n[OutIdxW-1:0]] = st_hi.first;
      n = n + 1'b1;
      if (st_hi.two) begin
        buf_d[n[OutIdxW-1:0]] = st_hi.second;
        n = n + 1'b1;
      end
      buf_d[n[OutIdxW-1:0]] = end_q;
      n = n + 1'b1;
    end
    last_idx_d = OutIdxW'(n - 1'b1);
  end

  // output lane
  assign out_o.valid      = buf_vld_q;
  assign out_o.out_byte   = buf_q[idx_q];
  assign out_o.run_last   = (idx_q == last_idx_q);
  assign out_o.frame_done = done_q && (idx_q == last_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      buf_vld_q  <= 1'b0;
      idx_q      <= '0;
      last_idx_q <= '0;
      done_q     <= 1'b0;
      in_frame_q <= 1'b0;
      sum_lo_q   <= '0;
      sum_hi_q   <= '0;
    end else begin
      if (in_fire) begin
        in_vld_q <= 1'b1;
      end else if (load) begin
        in_vld_q <= 1'b0;
      end
      if (load) begin
        buf_vld_q  <= 1'b1;
        idx_q      <= '0;
        last_idx_q <= last_idx_d;
        done_q     <= in_last_q;
        in_frame_q <= !in_last_q;
        sum_lo_q   <= in_last_q ? '0 : sum_lo_d;
        sum_hi_q   <= in_last_q ? '0 : sum_hi_d;
      end else if (buf_free) begin
        buf_vld_q <= 1'b0;
      end else if (out_fire) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_data_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
    if (load) begin
      buf_q <= buf_d;
    end
  end

  // configuration port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= HeaderRst;
      end_q <= EndRst;
      esc_q <= EscapeRst;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_HEADER: hdr_q <= pwdata[ByteW-1:0];
        REG_END:    end_q <= pwdata[ByteW-1:0];
        REG_ESCAPE: esc_q <= pwdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_HEADER: prdata = {{(PdataW-ByteW){1'b0}}, hdr_q};
      REG_END:    prdata = {{(PdataW-ByteW){1'b0}}, end_q};
      REG_ESCAPE: prdata = {{(PdataW-ByteW){1'b0}}, esc_q};
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/bsfe_checker.sv -----
// bsfe_checker: port-level assertions for the frame encoder, bound to the top level
// depends on bsfe_pkg and byte_stuffed_frame_encoder_top
`timescale 1ns / 1ps
`default_nettype none

module bsfe_checker
  import bsfe_pkg::*;
(
  input wire logic  clk_i,
  input wire logic  rst_ni,
  input wire logic  in_valid_i,
  input wire logic  in_ready_i,
  input wire logic  out_valid_i,
  input wire logic  out_ready_i,
  input wire byte_t out_byte_i,
  input wire logic  run_last_i,
  input wire logic  frame_done_i
);

  logic [1:0] pend_q;
  logic       in_fire, end_fire;

  assign in_fire  = in_valid_i && in_ready_i;
  assign end_fire = out_valid_i && out_ready_i && run_last_i;

  // requests accepted but not yet finished on the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_fire} - {1'b0, end_fire};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(run_last_i) && $stable(frame_done_i))
    else $error("output changed while stalled");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_done_i |-> run_last_i)
    else $error("end delimiter not last byte of request");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("output without pending request");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two requests in flight");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with idle output");

endmodule

bind byte_stuffed_frame_encoder_top bsfe_checker u_bsfe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_byte_i   (out_o.out_byte),
  .run_last_i   (out_o.run_last),
  .frame_done_i (out_o.frame_done)
);

`default_nettype wire
